// ----- hdl/lpht_pkg.sv -----
`default_nettype none
package lpht_pkg;

   // payload widths fixed by the channel definitions
   localparam int WORD_W = 64;
   localparam int SLOT_W = 12;
   localparam int OCC_W  = 13;

   localparam int DEF_TABLE_SLOTS = 4096;
   localparam int DEF_KEY_BYTES   = 16;
   localparam int DEF_VALUE_BYTES = 8;

   // operation codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_FIND   = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;

   // index of the last round in the integer hash
   localparam logic [2:0] HASH_LAST = 3'd6;

   // one table entry as held in memory
   typedef struct packed {
      logic              empty;
      logic [WORD_W-1:0] key_high;
      logic [WORD_W-1:0] key_low;
      logic [WORD_W-1:0] value;
   } lpht_entry_type;

   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] key;
   } lpht_hash_req_type;

   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] hash;
   } lpht_hash_rsp_type;

   // one round of the shift-add-xor hash
   function automatic logic [WORD_W-1:0] hash_round(input logic [2:0] idx,
                                                    input logic [WORD_W-1:0] k);
      logic [WORD_W-1:0] r;
      case (idx)
         3'd0: r = (k << 21) + ~k;
         3'd1: r = k ^ (k >> 24);
         3'd2: r = (k + (k << 3)) + (k << 8);
         3'd3: r = k ^ (k >> 14);
         3'd4: r = (k + (k << 2)) + (k << 4);
         3'd5: r = k ^ (k >> 28);
         3'd6: r = k + (k << 31);
         default: r = k;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/lpht_if.sv -----
`default_nettype none
interface lpht_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [63:0] key_high;
   logic [63:0] key_low;
   logic [63:0] value_in;

   modport source (output valid, op, key_high, key_low, value_in, input ready);
   modport sink (input valid, op, key_high, key_low, value_in, output ready);
endinterface

interface lpht_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [11:0] slot;
   logic [63:0] value_out;
   logic [12:0] occupancy;

   modport source (output valid, status, slot, value_out, occupancy, input ready);
   modport sink (input valid, status, slot, value_out, occupancy, output ready);
endinterface
`default_nettype wire

// ----- hdl/lpht_ram.sv -----
`default_nettype none
module lpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic                     we,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]              rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // single port, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule
`default_nettype wire

// ----- hdl/lpht_hash.sv -----
`default_nettype none
module lpht_hash
   import lpht_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  lpht_hash_req_type hreq,
   output lpht_hash_rsp_type hrsp
);

   logic [WORD_W-1:0] k_ff;
   logic [2:0]        rnd_ff;
   logic              busy_ff;
   logic              done_ff;

   // control: one round per cycle, pulse done after the last
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         rnd_ff  <= 3'd0;
      end else begin
         done_ff <= 1'b0;
         if (hreq.start) begin
            busy_ff <= 1'b1;
            rnd_ff  <= 3'd0;
         end else if (busy_ff) begin
            rnd_ff <= rnd_ff + 3'd1;
            if (rnd_ff == HASH_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (hreq.start) begin
         k_ff <= hreq.key;
      end else if (busy_ff) begin
         k_ff <= hash_round(rnd_ff, k_ff);
      end
   end

   assign hrsp.done = done_ff;
   assign hrsp.hash = k_ff;

endmodule
`default_nettype wire

// ----- hdl/linear_probe_hash_table.sv -----
`default_nettype none
// Channel  Dir  Word fields                          Accepted when
// req_     in   op, key_high, key_low, value_in      valid && ready
// rsp_     out  status, slot, value_out, occupancy   valid && ready
//
// One operation at a time. Each probed slot is read and then checked
// (single-port table memory, registered read), and during remove each
// shifted-over entry is read and its key rehashed.
// After reset a clearing pass marks every slot empty, with req_ ready
// low throughout.
// A finished result sits in the output register; the next word is taken
// meanwhile, and a result only waits when that register is still full.
module linear_probe_hash_table
   import lpht_pkg::*;
#(
   parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
   parameter int KEY_BYTES   = DEF_KEY_BYTES,
   parameter int VALUE_BYTES = DEF_VALUE_BYTES
) (
   input  wire logic   clock,
   input  wire logic   reset,
   lpht_req_if.sink    req_chan,
   lpht_rsp_if.source  rsp_chan
);

   localparam int SW      = $clog2(TABLE_SLOTS);
   localparam int HI_BITS = (KEY_BYTES - 8) * 8;
   localparam int VAL_BITS = VALUE_BYTES * 8;
   localparam logic [WORD_W-1:0] HI_MASK =
      (HI_BITS >= WORD_W) ? {WORD_W{1'b1}} : ((64'd1 << HI_BITS) - 64'd1);
   localparam logic [WORD_W-1:0] VAL_MASK =
      (VAL_BITS >= WORD_W) ? {WORD_W{1'b1}} : ((64'd1 << VAL_BITS) - 64'd1);
   localparam logic [SW:0] LAST_N  = (SW+1)'(TABLE_SLOTS - 1);
   localparam logic [SW:0] FULL_N  = (SW+1)'(TABLE_SLOTS);
   localparam logic [SW-1:0] LAST_SLOT = {SW{1'b1}};

   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_HASH    = 4'd2;
   localparam logic [3:0] S_RD      = 4'd3;
   localparam logic [3:0] S_CHK     = 4'd4;
   localparam logic [3:0] S_RM_RD   = 4'd5;
   localparam logic [3:0] S_RM_CHK  = 4'd6;
   localparam logic [3:0] S_RM_HASH = 4'd7;
   localparam logic [3:0] S_RM_END  = 4'd8;
   localparam logic [3:0] S_DONE    = 4'd9;

   logic [3:0]        state_ff, state_in;
   logic [SW-1:0]     clr_ff, clr_in;
   logic [SW:0]       cnt_ff, cnt_in;
   logic [1:0]        op_ff, op_in;
   logic [WORD_W-1:0] khi_ff, khi_in;
   logic [WORD_W-1:0] klo_ff, klo_in;
   logic [WORD_W-1:0] val_ff, val_in;
   logic [SW-1:0]     pos_ff, pos_in;
   logic [SW-1:0]     gap_ff, gap_in;
   logic [SW:0]       n_ff, n_in;
   lpht_entry_type    ent_ff, ent_in;
   logic [1:0]        st_ff, st_in;
   logic [SW-1:0]     slot_ff, slot_in;
   logic [WORD_W-1:0] vout_ff, vout_in;

   logic              rv_ff, rv_in;
   logic [1:0]        rstatus_ff, rstatus_in;
   logic [SLOT_W-1:0] rslot_ff, rslot_in;
   logic [WORD_W-1:0] rvout_ff, rvout_in;
   logic [OCC_W-1:0]  rocc_ff, rocc_in;

   logic [SW-1:0]     ram_addr;
   logic              ram_we;
   lpht_entry_type    ram_wdata;
   lpht_entry_type    ram_rdata;
   logic [$bits(lpht_entry_type)-1:0] ram_rbits;

   lpht_hash_req_type hash_req;
   lpht_hash_rsp_type hash_rsp;

   logic [SW-1:0]     home;
   logic [SW-1:0]     dist_h;
   logic [SW-1:0]     dist_c;
   logic              move;
   logic              key_hit;
   logic              out_free;

   lpht_ram #(
      .WIDTH ($bits(lpht_entry_type)),
      .DEPTH (TABLE_SLOTS)
   ) u_ram (
      .clock (clock),
      .addr  (ram_addr),
      .we    (ram_we),
      .wdata (ram_wdata),
      .rdata (ram_rbits)
   );
   assign ram_rdata = lpht_entry_type'(ram_rbits);

   lpht_hash u_hash (
      .clock (clock),
      .reset (reset),
      .hreq  (hash_req),
      .hrsp  (hash_rsp)
   );

   assign home     = hash_rsp.hash[SW-1:0];
   assign dist_h   = home - gap_ff;
   assign dist_c   = pos_ff - gap_ff;
   assign move     = (dist_h == '0) || (dist_h > dist_c);
   assign key_hit  = (ram_rdata.key_high == khi_ff) && (ram_rdata.key_low == klo_ff);
   assign out_free = !rv_ff || rsp_chan.ready;

   assign req_chan.ready = (state_ff == S_IDLE);

   // sequencer: probe, insert, find, backward-shift remove
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      cnt_in   = cnt_ff;
      op_in    = op_ff;
      khi_in   = khi_ff;
      klo_in   = klo_ff;
      val_in   = val_ff;
      pos_in   = pos_ff;
      gap_in   = gap_ff;
      n_in     = n_ff;
      ent_in   = ent_ff;
      st_in    = st_ff;
      slot_in  = slot_ff;
      vout_in  = vout_ff;
      ram_addr  = pos_ff;
      ram_we    = 1'b0;
      ram_wdata = '{empty: 1'b1, key_high: '0, key_low: '0, value: '0};
      hash_req  = '{start: 1'b0, key: klo_ff};

      case (state_ff)
         S_CLEAR: begin
            ram_addr = clr_ff;
            ram_we   = 1'b1;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == LAST_SLOT) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_chan.valid) begin
               op_in   = req_chan.op;
               khi_in  = req_chan.key_high & HI_MASK;
               klo_in  = req_chan.key_low;
               val_in  = req_chan.value_in & VAL_MASK;
               st_in   = ST_NOTFOUND;
               slot_in = '0;
               vout_in = '0;
               if (req_chan.op == OP_INSERT && cnt_ff == FULL_N) begin
                  st_in    = ST_FULL;
                  state_in = S_DONE;
               end else if (req_chan.op inside {OP_INSERT, OP_FIND, OP_REMOVE}) begin
                  hash_req = '{start: 1'b1, key: req_chan.key_low};
                  state_in = S_HASH;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_HASH: begin
            if (hash_rsp.done) begin
               pos_in   = home;
               n_in     = '0;
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = S_CHK;
         end
         S_CHK: begin
            if (op_ff == OP_INSERT) begin
               if (ram_rdata.empty) begin
                  ram_we    = 1'b1;
                  ram_wdata = '{empty: 1'b0, key_high: khi_ff, key_low: klo_ff,
                                value: val_ff};
                  cnt_in    = cnt_ff + 1'b1;
                  st_in     = ST_OK;
                  slot_in   = pos_ff;
                  state_in  = S_DONE;
               end else begin
                  pos_in   = pos_ff + 1'b1;
                  n_in     = n_ff + 1'b1;
                  state_in = S_RD;
               end
            end else if (ram_rdata.empty) begin
               state_in = S_DONE;
            end else if (key_hit) begin
               st_in   = ST_OK;
               slot_in = pos_ff;
               vout_in = ram_rdata.value;
               if (op_ff == OP_REMOVE) begin
                  gap_in   = pos_ff;
                  pos_in   = pos_ff + 1'b1;
                  n_in     = (SW+1)'(1);
                  state_in = S_RM_RD;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               pos_in = pos_ff + 1'b1;
               n_in   = n_ff + 1'b1;
               if (n_ff == LAST_N) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_RM_RD: begin
            state_in = S_RM_CHK;
         end
         S_RM_CHK: begin
            if (ram_rdata.empty) begin
               state_in = S_RM_END;
            end else begin
               ent_in   = ram_rdata;
               hash_req = '{start: 1'b1, key: ram_rdata.key_low};
               state_in = S_RM_HASH;
            end
         end
         S_RM_HASH: begin
            if (hash_rsp.done) begin
               // pull the entry back into the gap when it lost its path home
               if (move) begin
                  ram_addr  = gap_ff;
                  ram_we    = 1'b1;
                  ram_wdata = ent_ff;
                  gap_in    = pos_ff;
               end
               pos_in = pos_ff + 1'b1;
               n_in   = n_ff + 1'b1;
               if (n_ff == LAST_N) begin
                  state_in = S_RM_END;
               end else begin
                  state_in = S_RM_RD;
               end
            end
         end
         S_RM_END: begin
            ram_addr = gap_ff;
            ram_we   = 1'b1;
            if (cnt_ff != '0) begin
               cnt_in = cnt_ff - 1'b1;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // output register
   always_comb begin
      rv_in      = rv_ff;
      rstatus_in = rstatus_ff;
      rslot_in   = rslot_ff;
      rvout_in   = rvout_ff;
      rocc_in    = rocc_ff;
      if (rv_ff && rsp_chan.ready) begin
         rv_in = 1'b0;
      end
      if (state_ff == S_DONE && out_free) begin
         rv_in      = 1'b1;
         rstatus_in = st_ff;
         rslot_in   = SLOT_W'(slot_ff);
         rvout_in   = vout_ff;
         rocc_in    = OCC_W'(cnt_ff);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         cnt_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         cnt_ff   <= cnt_in;
         rv_ff    <= rv_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      khi_ff     <= khi_in;
      klo_ff     <= klo_in;
      val_ff     <= val_in;
      pos_ff     <= pos_in;
      gap_ff     <= gap_in;
      n_ff       <= n_in;
      ent_ff     <= ent_in;
      st_ff      <= st_in;
      slot_ff    <= slot_in;
      vout_ff    <= vout_in;
      rstatus_ff <= rstatus_in;
      rslot_ff   <= rslot_in;
      rvout_ff   <= rvout_in;
      rocc_ff    <= rocc_in;
   end

   assign rsp_chan.valid     = rv_ff;
   assign rsp_chan.status    = rstatus_ff;
   assign rsp_chan.slot      = rslot_ff;
   assign rsp_chan.value_out = rvout_ff;
   assign rsp_chan.occupancy = rocc_ff;

`ifndef SYNTHESIS
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FULL_N)
      else $error("occupancy above table size");

   a_hash_owner: assert property (@(posedge clock) disable iff (reset)
      hash_rsp.done |-> (state_ff == S_HASH || state_ff == S_RM_HASH))
      else $error("hash result with no waiting state");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_DONE) |-> !ram_we)
      else $error("table write outside an operation");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rv_ff) |-> $past(state_ff == S_DONE))
      else $error("result word without a finished operation");
`endif

endmodule
`default_nettype wire
